>>> rtl/mhc_pkg.sv
`timescale 1ns / 1ps

package mhc_pkg;

    typedef enum logic [1:0] {
        MODE_MEASURE = 2'd0,
        MODE_CLEAR   = 2'd1,
        MODE_SAMPLE  = 2'd2,
        MODE_FINISH  = 2'd3
    } mode_t;

    // Rotator datapath widths: x/y hold the normalized vector plus the CORDIC gain,
    // z holds the angle in 1/256 centidegree.
    localparam int CW        = 37;
    localparam int ZW        = 25;
    localparam int ATAN_LEN  = 24;

    localparam logic [15:0]          RESET_TRIM = 16'd10633;
    localparam logic signed [ZW-1:0] HALF_TURN  = 25'sd4608000;

    typedef struct packed {
        logic valid;
        logic heading;
        logic calibrated;
        logic zero;
    } side_t;

    typedef struct packed {
        side_t                side;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
    } cordic_t;

    // atan(2^-i) in 1/256 centidegree
    function automatic logic signed [ZW-1:0] atan_entry(input int i);
        logic signed [ZW-1:0] a;
        case (i)
            0:       a = 25'sd1152000;
            1:       a = 25'sd680065;
            2:       a = 25'sd359328;
            3:       a = 25'sd182400;
            4:       a = 25'sd91554;
            5:       a = 25'sd45822;
            6:       a = 25'sd22916;
            7:       a = 25'sd11459;
            8:       a = 25'sd5730;
            9:       a = 25'sd2865;
            10:      a = 25'sd1432;
            11:      a = 25'sd716;
            12:      a = 25'sd358;
            13:      a = 25'sd179;
            14:      a = 25'sd90;
            15:      a = 25'sd45;
            16:      a = 25'sd22;
            17:      a = 25'sd11;
            18:      a = 25'sd6;
            19:      a = 25'sd3;
            20:      a = 25'sd1;
            21:      a = 25'sd1;
            default: a = 25'sd0;
        endcase
        return a;
    endfunction

endpackage

>>> rtl/mhc_in_if.sv
`timescale 1ns / 1ps

interface mhc_in_if;
    logic              valid;
    logic              ready;
    logic [1:0]        mode;
    logic signed [15:0] raw_y;
    logic signed [15:0] raw_z;

    modport source (output valid, output mode, output raw_y, output raw_z, input ready);
    modport sink   (input valid, input mode, input raw_y, input raw_z, output ready);
endinterface

>>> rtl/mhc_out_if.sv
`timescale 1ns / 1ps

interface mhc_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] heading_centideg;
    logic        heading_valid;
    logic        calibrated;

    modport source (output valid, output heading_centideg, output heading_valid,
                    output calibrated, input ready);
    modport sink   (input valid, input heading_centideg, input heading_valid,
                    input calibrated, output ready);
endinterface

>>> rtl/mhc_front.sv
`timescale 1ns / 1ps

module mhc_front
    import mhc_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  logic               fire,
    input  logic [1:0]         mode,
    input  logic signed [15:0] raw_y,
    input  logic signed [15:0] raw_z,
    output side_t              side,
    output logic signed [17:0] cy,
    output logic signed [17:0] cz,
    output logic signed [16:0] dy,
    output logic signed [16:0] dz
);

    localparam logic signed [15:0] LOW_RST  = 16'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [15:0] HIGH_RST = 16'(-(1 << (SAMPLE_BITS - 1)));

    logic signed [15:0] y_low_reg, y_low_next, y_high_reg, y_high_next;
    logic signed [15:0] z_low_reg, z_low_next, z_high_reg, z_high_next;
    logic               seen_reg, seen_next;
    logic signed [16:0] y_cs_reg, y_cs_next, z_cs_reg, z_cs_next;
    logic [15:0]        y_span_reg, y_span_next, z_span_reg, z_span_next;

    side_t              side_reg, side_next;
    logic signed [17:0] cy_reg, cy_next, cz_reg, cz_next;
    logic signed [16:0] dy_reg, dy_next, dz_reg, dz_next;

    logic signed [15:0] ry, rz;
    mode_t              m;

    always_comb
    begin
        ry = 16'($signed(raw_y[SAMPLE_BITS-1:0]));
        rz = 16'($signed(raw_z[SAMPLE_BITS-1:0]));
        m  = mode_t'(mode);

        y_low_next  = y_low_reg;
        y_high_next = y_high_reg;
        z_low_next  = z_low_reg;
        z_high_next = z_high_reg;
        seen_next   = seen_reg;
        y_cs_next   = y_cs_reg;
        z_cs_next   = z_cs_reg;
        y_span_next = y_span_reg;
        z_span_next = z_span_reg;

        if (fire)
        begin
            case (m)
                MODE_CLEAR:
                begin
                    y_low_next  = LOW_RST;
                    y_high_next = HIGH_RST;
                    z_low_next  = LOW_RST;
                    z_high_next = HIGH_RST;
                    seen_next   = 1'b0;
                end
                MODE_SAMPLE:
                begin
                    if (ry < y_low_reg)  y_low_next  = ry;
                    if (ry > y_high_reg) y_high_next = ry;
                    if (rz < z_low_reg)  z_low_next  = rz;
                    if (rz > z_high_reg) z_high_next = rz;
                    seen_next = 1'b1;
                end
                MODE_FINISH:
                begin
                    if (seen_reg)
                    begin
                        y_cs_next   = 17'(y_low_reg) + 17'(y_high_reg);
                        z_cs_next   = 17'(z_low_reg) + 17'(z_high_reg);
                        y_span_next = 16'(y_high_reg - y_low_reg);
                        z_span_next = 16'(z_high_reg - z_low_reg);
                    end
                    else
                    begin
                        y_cs_next   = '0;
                        z_cs_next   = '0;
                        y_span_next = '0;
                        z_span_next = '0;
                    end
                end
                default: ;
            endcase
        end

        // center on twice the raw value; an axis with no span divides by 2
        cy_next = (18'(ry) <<< 1) - 18'(y_cs_reg);
        cz_next = (18'(rz) <<< 1) - 18'(z_cs_reg);
        dy_next = (y_span_reg != '0) ? $signed({1'b0, y_span_reg}) : 17'sd2;
        dz_next = (z_span_reg != '0) ? $signed({1'b0, z_span_reg}) : 17'sd2;

        side_next.valid      = fire;
        side_next.heading    = (m == MODE_MEASURE);
        side_next.calibrated = (y_span_next != '0) && (z_span_next != '0);
        side_next.zero       = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            y_low_reg  <= LOW_RST;
            y_high_reg <= HIGH_RST;
            z_low_reg  <= LOW_RST;
            z_high_reg <= HIGH_RST;
            seen_reg   <= 1'b0;
            y_cs_reg   <= '0;
            z_cs_reg   <= '0;
            y_span_reg <= '0;
            z_span_reg <= '0;
            side_reg   <= '0;
        end
        else
        begin
            y_low_reg  <= y_low_next;
            y_high_reg <= y_high_next;
            z_low_reg  <= z_low_next;
            z_high_reg <= z_high_next;
            seen_reg   <= seen_next;
            y_cs_reg   <= y_cs_next;
            z_cs_reg   <= z_cs_next;
            y_span_reg <= y_span_next;
            z_span_reg <= z_span_next;
            if (advance)
                side_reg <= side_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            cy_reg <= cy_next;
            cz_reg <= cz_next;
            dy_reg <= dy_next;
            dz_reg <= dz_next;
        end
    end

    assign side = side_reg;
    assign cy   = cy_reg;
    assign cz   = cz_reg;
    assign dy   = dy_reg;
    assign dz   = dz_reg;

    a_trackers_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg |-> (y_low_reg <= y_high_reg) && (z_low_reg <= z_high_reg))
        else $error("tracker low above high after a sample");

    a_trackers_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !seen_reg |-> (y_low_reg == LOW_RST) && (y_high_reg == HIGH_RST)
                      && (z_low_reg == LOW_RST) && (z_high_reg == HIGH_RST))
        else $error("trackers moved without a sample");

    a_divisor_positive: assert property (@(posedge clk) disable iff (!rst_n)
        side_reg.valid |-> (dy_reg > 17'sd0) && (dz_reg > 17'sd0))
        else $error("axis scale not positive");

endmodule

>>> rtl/mhc_norm.sv
`timescale 1ns / 1ps

module mhc_norm
    import mhc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  side_t              side,
    input  logic signed [17:0] cy,
    input  logic signed [17:0] cz,
    input  logic signed [16:0] dy,
    input  logic signed [16:0] dz,
    output cordic_t            vec
);

    typedef struct packed {
        logic [34:0]        m;
        logic signed [34:0] x;
        logic signed [34:0] y;
    } norm_t;

    // shift left by s when the magnitude stays below 2^33 afterwards
    function automatic norm_t norm_step(input norm_t v, input int s);
        norm_t r;
        r = v;
        if (v.m < (35'd1 << (33 - s)))
        begin
            r.m = v.m << s;
            r.x = v.x <<< s;
            r.y = v.y <<< s;
        end
        return r;
    endfunction

    side_t              side2_reg, side3_reg, side3_next, side4_reg, side5_reg;
    logic signed [34:0] px_reg, px_next, py_reg, py_next;
    norm_t              v3_reg, v3_next, v4_reg, v4_next, v5_reg, v5_next;
    logic signed [ZW-1:0] z3_reg, z3_next, z4_reg, z5_reg;
    logic [34:0]        ax, ay;

    always_comb
    begin
        // cross-multiply instead of dividing by the spans
        px_next = 35'(cz) * 35'(dy);
        py_next = -(35'(cy) * 35'(dz));

        ax = px_reg[34] ? 35'(-px_reg) : 35'(px_reg);
        ay = py_reg[34] ? 35'(-py_reg) : 35'(py_reg);

        v3_next.m = (ax > ay) ? ax : ay;
        // fold the left half plane onto the right, starting from +/-180 degrees
        if (px_reg[34])
        begin
            v3_next.x = -px_reg;
            v3_next.y = -py_reg;
            z3_next   = py_reg[34] ? -HALF_TURN : HALF_TURN;
        end
        else
        begin
            v3_next.x = px_reg;
            v3_next.y = py_reg;
            z3_next   = '0;
        end
        side3_next      = side2_reg;
        side3_next.zero = (ax == '0) && (ay == '0);

        v4_next = norm_step(norm_step(v3_reg, 16), 8);
        v5_next = norm_step(norm_step(norm_step(norm_step(v4_reg, 4), 2), 1), 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side2_reg <= '0;
            side3_reg <= '0;
            side4_reg <= '0;
            side5_reg <= '0;
        end
        else if (advance)
        begin
            side2_reg <= side;
            side3_reg <= side3_next;
            side4_reg <= side3_reg;
            side5_reg <= side4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            px_reg <= px_next;
            py_reg <= py_next;
            v3_reg <= v3_next;
            z3_reg <= z3_next;
            v4_reg <= v4_next;
            z4_reg <= z3_reg;
            v5_reg <= v5_next;
            z5_reg <= z4_reg;
        end
    end

    assign vec.side = side5_reg;
    assign vec.x    = CW'(v5_reg.x);
    assign vec.y    = CW'(v5_reg.y);
    assign vec.z    = z5_reg;

endmodule

>>> rtl/mhc_cordic_cell.sv
`timescale 1ns / 1ps

module mhc_cordic_cell
    import mhc_pkg::*;
#(
    parameter int                   STEP = 0,
    parameter logic signed [ZW-1:0] ATAN = '0
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    advance,
    input  cordic_t din,
    output cordic_t dout
);

    cordic_t              cell_reg, cell_next;
    logic signed [CW-1:0] xs, ys;

    always_comb
    begin
        xs = din.x >>> STEP;
        ys = din.y >>> STEP;
        cell_next.side = din.side;
        // rotate toward the x axis
        if (din.y > 0)
        begin
            cell_next.x = din.x + ys;
            cell_next.y = din.y - xs;
            cell_next.z = din.z + ATAN;
        end
        else
        begin
            cell_next.x = din.x - ys;
            cell_next.y = din.y + xs;
            cell_next.z = din.z - ATAN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cell_reg <= '0;
        else if (advance)
            cell_reg <= cell_next;
    end

    assign dout = cell_reg;

endmodule

>>> rtl/magnetometer_calibrated_heading_core.sv
`timescale 1ns / 1ps
// Channel   Dir  Handshake            Payload
// meas      in   valid/ready          mode, raw_y, raw_z
// result    out  valid/ready          heading_centideg, heading_valid, calibrated
// cfg       in   cfg_we (no ready)    cfg_wdata -> heading_trim
//
// One item per cycle while the pipeline is not held; a result passes through the
// calibration stage, multiply, three normalize stages, one CORDIC cell per step
// (min(CORDIC_STEPS,24) cells), trim add, then the wrap into the output register.
// Calibration state updates at the input transfer, so later items see it at once.
// Reset clears the trackers, stored calibration and all stage valids; trim returns
// to 10633. The pipeline holds only when the output register and the trim stage
// are both full and result is not ready; otherwise it keeps taking items.

module magnetometer_calibrated_heading_core
    import mhc_pkg::*;
#(
    parameter int CORDIC_STEPS = 16,
    parameter int SAMPLE_BITS  = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    mhc_in_if.sink      meas,
    mhc_out_if.source   result,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);

    localparam int N_CELLS = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;

    logic               advance, fire;
    logic [15:0]        trim_reg;
    side_t              front_side;
    logic signed [17:0] cy, cz;
    logic signed [16:0] dy, dz;
    cordic_t            chain [N_CELLS+1];

    side_t              f1_side_reg;
    logic signed [17:0] cd_reg, cd_next, wrap;
    logic signed [ZW-1:0] z_eff;
    logic signed [16:0] rnd;

    logic               out_valid_reg;
    logic [15:0]        heading_reg, heading_next;
    logic               hvalid_reg, cal_reg;

    // hold everything only when the trim stage cannot move into a full output
    assign advance    = !(f1_side_reg.valid && out_valid_reg && !result.ready);
    assign fire       = meas.valid && advance;
    assign meas.ready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            trim_reg <= RESET_TRIM;
        else if (cfg_we)
            trim_reg <= cfg_wdata;
    end

    mhc_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .fire    (fire),
        .mode    (meas.mode),
        .raw_y   (meas.raw_y),
        .raw_z   (meas.raw_z),
        .side    (front_side),
        .cy      (cy),
        .cz      (cz),
        .dy      (dy),
        .dz      (dz)
    );

    mhc_norm u_norm (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .side    (front_side),
        .cy      (cy),
        .cz      (cz),
        .dy      (dy),
        .dz      (dz),
        .vec     (chain[0])
    );

    for (genvar i = 0; i < N_CELLS; i++)
    begin : g_cell
        mhc_cordic_cell #(.STEP(i), .ATAN(atan_entry(i))) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .din     (chain[i]),
            .dout    (chain[i+1])
        );
    end

    always_comb
    begin
        // a zero vector has angle zero
        z_eff   = chain[N_CELLS].side.zero ? '0 : chain[N_CELLS].z;
        rnd     = 17'((z_eff + 25'sd128) >>> 8);
        cd_next = 18'(rnd) + $signed({2'b00, trim_reg});

        if (cd_reg < 18'sd0)
            wrap = cd_reg + 18'sd36000;
        else if (cd_reg >= 18'sd72000)
            wrap = cd_reg - 18'sd72000;
        else if (cd_reg >= 18'sd36000)
            wrap = cd_reg - 18'sd36000;
        else
            wrap = cd_reg;
        heading_next = f1_side_reg.heading ? 16'(wrap) : 16'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_side_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
                f1_side_reg <= chain[N_CELLS].side;
            if (advance && f1_side_reg.valid)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            cd_reg <= cd_next;
        if (advance && f1_side_reg.valid)
        begin
            heading_reg <= heading_next;
            hvalid_reg  <= f1_side_reg.heading;
            cal_reg     <= f1_side_reg.calibrated;
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.heading_centideg = heading_reg;
    assign result.heading_valid    = hvalid_reg;
    assign result.calibrated       = cal_reg;

    a_trim_sum_range: assert property (@(posedge clk) disable iff (!rst_n)
        f1_side_reg.valid |-> (cd_reg > -18'sd36000) && (cd_reg < 18'sd108000))
        else $error("trimmed angle outside wrap range");

    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && hvalid_reg |-> heading_reg < 16'd36000)
        else $error("heading not wrapped");

    a_no_heading_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !hvalid_reg |-> heading_reg == 16'd0)
        else $error("heading set on a calibration item");

endmodule
